[sv/rdd_pkg.sv]
package rdd_pkg;

    localparam int MAX_BYTES_DEF = 256;

    typedef struct packed {
        logic cmp;      // byte takes part in the comparison against the stored packet
        logic resend;
        logic last;
    } rdd_flags_t;

endpackage

[sv/resend_duplicate_detector.sv]
// A packet's result passes the store registers, then the result register, to out_valid.
// Throughput: one item per cycle; the result register frees the input side
// unless a finished result is stalled while another packet end waits behind it.
// Rate is set by the single-port byte store, read once per item and written once per stored byte.
// Reset (rst_n, asynchronous, active low) clears the length, position, resend
// mark and valid flags; the byte store holds no reset value.
module resend_duplicate_detector #(
    parameter int MAX_BYTES = rdd_pkg::MAX_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       byte_present,
    input  logic       resend_flag,
    input  logic       packet_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       is_duplicate
);
    import rdd_pkg::*;

    localparam int LW = $clog2(MAX_BYTES + 1);

    logic          accept;
    logic          hold;
    logic [7:0]    byte_q;
    logic [7:0]    stored_q;
    logic [LW-1:0] pos_q;
    logic [LW-1:0] len_q;
    rdd_flags_t    flags_q;

    assign in_stall = hold;
    assign accept   = in_valid && !hold;

    rdd_store #(
        .MAX_BYTES (MAX_BYTES)
    ) u_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .resend_flag  (resend_flag),
        .packet_last  (packet_last),
        .byte_q       (byte_q),
        .stored_q     (stored_q),
        .pos_q        (pos_q),
        .len_q        (len_q),
        .flags_q      (flags_q)
    );

    rdd_judge #(
        .LW (LW)
    ) u_judge (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .byte_q       (byte_q),
        .stored_q     (stored_q),
        .pos_q        (pos_q),
        .len_q        (len_q),
        .flags_q      (flags_q),
        .hold         (hold),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .is_duplicate (is_duplicate)
    );

endmodule

[sv/rdd_store.sv]
module rdd_store #(
    parameter int MAX_BYTES = rdd_pkg::MAX_BYTES_DEF,
    parameter int LW        = $clog2(MAX_BYTES + 1),
    parameter int AW        = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic                byte_present,
    input  logic                resend_flag,
    input  logic                packet_last,
    output logic [7:0]          byte_q,
    output logic [7:0]          stored_q,
    output logic [LW-1:0]       pos_q,
    output logic [LW-1:0]       len_q,
    output rdd_pkg::rdd_flags_t flags_q
);
    import rdd_pkg::*;

    logic [7:0]    mem [MAX_BYTES];
    logic [7:0]    rd_reg;
    logic [7:0]    byte_reg;
    logic [LW-1:0] pos_reg;
    logic [LW-1:0] len_reg;
    rdd_flags_t    flags_reg;

    logic [LW-1:0] byte_position_reg;
    logic [LW-1:0] byte_position_next;
    logic          in_range;
    logic          take;
    logic [LW-1:0] len_now;
    logic [AW-1:0] addr;

    assign in_range = (byte_position_reg < LW'(MAX_BYTES));
    assign take     = byte_present && in_range;
    assign len_now  = take ? (byte_position_reg + LW'(1)) : byte_position_reg;
    assign addr     = byte_position_reg[AW-1:0];

    always_comb
    begin
        byte_position_next = byte_position_reg;
        if (accept)
        begin
            byte_position_next = packet_last ? '0 : len_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= '0;
        end
        else
        begin
            byte_position_reg <= byte_position_next;
        end
    end

    // Resend bytes never write; a stored byte's read at its address returns the old contents, which go unused
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (take && !resend_flag)
            begin
                mem[addr] <= data_byte;
            end
            rd_reg    <= mem[addr];
            byte_reg  <= data_byte;
            pos_reg   <= byte_position_reg;
            len_reg   <= len_now;
            flags_reg <= '{cmp: take && resend_flag, resend: resend_flag, last: packet_last};
        end
    end

    assign byte_q   = byte_reg;
    assign stored_q = rd_reg;
    assign pos_q    = pos_reg;
    assign len_q    = len_reg;
    assign flags_q  = flags_reg;

endmodule

[sv/rdd_judge.sv]
module rdd_judge #(
    parameter int LW = $clog2(rdd_pkg::MAX_BYTES_DEF + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          byte_q,
    input  logic [7:0]          stored_q,
    input  logic [LW-1:0]       pos_q,
    input  logic [LW-1:0]       len_q,
    input  rdd_pkg::rdd_flags_t flags_q,
    output logic                hold,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                is_duplicate
);
    import rdd_pkg::*;

    logic          s1_valid_reg, s1_valid_next;
    logic          mismatch_seen_reg, mismatch_seen_next;
    logic          prev_resend_reg, prev_resend_next;
    logic [LW-1:0] stored_length_reg, stored_length_next;
    logic          out_valid_reg, out_valid_next;
    logic          dup_reg, dup_next;

    logic out_free;
    logic s1_go;
    logic mism;
    logic dup;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_go    = s1_valid_reg && (!flags_q.last || out_free);
    assign hold     = s1_valid_reg && !s1_go;

    assign mism = mismatch_seen_reg
                  || (flags_q.cmp && (pos_q < stored_length_reg) && (stored_q != byte_q));
    assign dup  = flags_q.resend && !prev_resend_reg && (len_q == stored_length_reg) && !mism;

    always_comb
    begin
        s1_valid_next      = accept || hold;
        mismatch_seen_next = mismatch_seen_reg;
        prev_resend_next   = prev_resend_reg;
        stored_length_next = stored_length_reg;
        out_valid_next     = out_valid_reg && out_stall;
        dup_next           = dup_reg;
        if (s1_go)
        begin
            if (flags_q.last)
            begin
                mismatch_seen_next = 1'b0;
                out_valid_next     = 1'b1;
                dup_next           = dup;
                if (!flags_q.resend)
                begin
                    stored_length_next = len_q;
                    prev_resend_next   = 1'b0;
                end
                else if (!dup)
                begin
                    prev_resend_next = 1'b1;
                end
            end
            else
            begin
                mismatch_seen_next = mism;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            mismatch_seen_reg <= 1'b0;
            prev_resend_reg   <= 1'b0;
            stored_length_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg      <= s1_valid_next;
            mismatch_seen_reg <= mismatch_seen_next;
            prev_resend_reg   <= prev_resend_next;
            stored_length_reg <= stored_length_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dup_reg <= dup_next;
    end

    assign out_valid    = out_valid_reg;
    assign is_duplicate = dup_reg;

endmodule

[sv/rdd_checker.sv]
module rdd_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic packet_last,
    input logic out_valid,
    input logic out_stall,
    input logic is_duplicate
);

    // A new result only follows an accepted packet end, through the store and result registers
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && packet_last, 2))
        else $error("result without a packet end two cycles before");

    // Input side stalls only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while result side is free");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(is_duplicate))
        else $error("stalled result changed");

endmodule

bind resend_duplicate_detector rdd_checker u_rdd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .packet_last  (packet_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .is_duplicate (is_duplicate)
);

[tb/resend_duplicate_detector_tb.sv]
module resend_duplicate_detector_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BYTES = rdd_pkg::MAX_BYTES_DEF;
    localparam int PHASE_REQUESTS = 150;

    typedef struct {
        logic [7:0] data;
        bit         present;
        bit         resend;
        bit         last;
    } rx_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte = 8'h00;
    logic       byte_present = 1'b0;
    logic       resend_flag = 1'b0;
    logic       packet_last = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       is_duplicate;

    // Shadow of the detector state
    logic [7:0] shadow_bytes [MAX_BYTES];
    bit         shadow_written [MAX_BYTES];
    int         shadow_length = 0;
    bit         shadow_resend_mark = 1'b0;
    int         shadow_position = 0;
    bit         shadow_mismatch = 1'b0;

    bit         dup_verdicts [$];
    bit         verdict_expected;

    int idle_pct = 0;
    int stall_pct = 0;
    int error_count = 0;
    int requests_sent = 0;
    int verdicts_checked = 0;
    int duplicates_seen = 0;

    resend_duplicate_detector #(
        .MAX_BYTES(MAX_BYTES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_byte(data_byte),
        .byte_present(byte_present),
        .resend_flag(resend_flag),
        .packet_last(packet_last),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .is_duplicate(is_duplicate)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $realtime, msg);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (dup_verdicts.size() == 0)
                report_mismatch($sformatf("verdict %0b with no packet outstanding",
                                          is_duplicate));
            else
            begin
                verdict_expected = dup_verdicts.pop_front();
                if (is_duplicate !== verdict_expected)
                    report_mismatch($sformatf("is_duplicate %b, expected %0b",
                                              is_duplicate, verdict_expected));
                verdicts_checked++;
                if (verdict_expected)
                    duplicates_seen++;
            end
        end
    end

    task automatic judge_request(input logic [7:0] d, input bit present, input bit resend,
                                 input bit last);
        bit dup;
        if (present)
        begin
            if (shadow_position < MAX_BYTES)
            begin
                if (!resend)
                begin
                    shadow_bytes[shadow_position] = d;
                    shadow_written[shadow_position] = 1'b1;
                end
                else if (shadow_position < shadow_length &&
                         shadow_bytes[shadow_position] != d)
                    shadow_mismatch = 1'b1;
                shadow_position++;
            end
        end
        if (last)
        begin
            dup = 1'b0;
            if (!resend)
            begin
                shadow_length = shadow_position;
                shadow_resend_mark = 1'b0;
            end
            else
            begin
                dup = !shadow_resend_mark && shadow_position == shadow_length &&
                      !shadow_mismatch;
                if (!dup)
                    shadow_resend_mark = 1'b1;
            end
            shadow_position = 0;
            shadow_mismatch = 1'b0;
            dup_verdicts.push_back(dup);
        end
    endtask

    task automatic send_item(input logic [7:0] d, input bit present, input bit resend,
                             input bit last);
        // Store the byte instead of comparing it against a slot never written
        if (present && resend && shadow_position < MAX_BYTES &&
            shadow_position < shadow_length && !shadow_written[shadow_position])
            resend = 1'b0;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        in_valid <= 1'b1;
        data_byte <= d;
        byte_present <= present;
        resend_flag <= resend;
        packet_last <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        judge_request(d, present, resend, last);
        if (present || last)
            requests_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (dup_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_packet(input logic [7:0] bytes [$], input bit resend);
        if (bytes.size() == 0)
            send_item(8'($urandom), 1'b0, resend, 1'b1);
        foreach (bytes[i])
            send_item(bytes[i], 1'b1, resend, i == bytes.size() - 1);
    endtask

    task automatic send_seq(input rx_item_t seq [$]);
        foreach (seq[i])
            send_item(seq[i].data, seq[i].present, seq[i].resend, seq[i].last);
    endtask

    task automatic send_resend_variant(input logic [7:0] orig [$]);
        logic [7:0] b [$];
        rx_item_t   seq [$];
        rx_item_t   gap_item;
        int         v;
        int         k;
        b = orig;
        v = $urandom_range(99);
        if (v >= 50 && v < 65 && b.size() != 0)
        begin
            k = $urandom_range(b.size() - 1);
            b[k] = b[k] ^ (8'h01 << $urandom_range(7));
        end
        else if (v >= 65 && v < 75)
        begin
            if ($urandom_range(1) == 1 && b.size() != 0)
                void'(b.pop_back());
            else
                b.push_back(8'($urandom));
        end
        foreach (b[i])
            seq.push_back('{b[i], 1'b1, 1'b1, 1'b0});
        if (v >= 75 && v < 85)
        begin
            foreach (seq[i])
                seq[i].resend = 1'($urandom_range(1));
        end
        if (v >= 85 && v < 95)
        begin
            repeat ($urandom_range(3, 1))
            begin
                gap_item = '{8'($urandom), 1'b0, 1'($urandom_range(1)), 1'b0};
                seq.insert($urandom_range(seq.size()), gap_item);
            end
        end
        // Close with a byteless item now and then
        if (v >= 95 || seq.size() == 0)
            seq.push_back('{8'($urandom), 1'b0, 1'b1, 1'b1});
        else
            seq[seq.size() - 1].last = 1'b1;
        send_seq(seq);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(6, 1))
            send_item(8'($urandom), $urandom_range(99) < 70, 1'($urandom_range(1)),
                      $urandom_range(99) < 30);
    endtask

    task automatic test_directed();
        send_item(8'h00, 1'b0, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b1, 1'b1);
        send_packet({8'h00, 8'hFF, 8'h5A}, 1'b0);
        send_packet({8'h00, 8'hFF, 8'h5A}, 1'b1);
        send_packet({8'h00, 8'hFE, 8'h5A}, 1'b1);
        // resend mark now set: an exact copy is no longer a duplicate
        send_packet({8'h00, 8'hFF, 8'h5A}, 1'b1);
        send_packet({8'hA5, 8'h3C}, 1'b0);
        send_packet({8'hA5, 8'h3C, 8'h77}, 1'b1);
        send_packet({8'hA5, 8'h3C}, 1'b0);
        send_packet({8'hA5}, 1'b1);
        send_packet({8'hA5, 8'h3C}, 1'b0);
        // mixed flags: first byte stored, second compared, byteless close
        send_item(8'h11, 1'b1, 1'b0, 1'b0);
        send_item(8'h3C, 1'b1, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1, 1'b1);
        send_item(8'h42, 1'b1, 1'b1, 1'b0);
        send_item(8'h43, 1'b1, 1'b0, 1'b1);
        drain_results();
    endtask

    task automatic test_long_packets();
        logic [7:0] b [$];
        logic [7:0] c [$];
        repeat (MAX_BYTES + 2)
            b.push_back(8'($urandom));
        send_packet(b, 1'b0);
        // differs only past the saturation point
        c = b;
        c[MAX_BYTES] = ~c[MAX_BYTES];
        c[MAX_BYTES + 1] = ~c[MAX_BYTES + 1];
        send_packet(c, 1'b1);
        c = b[0:MAX_BYTES - 2];
        send_packet(c, 1'b1);
        drain_results();
    endtask

    task automatic test_random_traffic(input int gap_pct, input int hold_pct);
        logic [7:0] orig [$];
        int start_count;
        int len;
        int sel;
        drain_results();
        idle_pct = gap_pct;
        stall_pct = hold_pct;
        start_count = requests_sent;
        while (requests_sent - start_count < PHASE_REQUESTS)
        begin
            sel = $urandom_range(99);
            if (sel < 10)
                send_noise();
            else
            begin
                sel = $urandom_range(99);
                if (sel < 10)
                    len = 0;
                else
                    len = $urandom_range(12, 1);
                orig.delete();
                repeat (len)
                    orig.push_back(8'($urandom));
                send_packet(orig, 1'b0);
                repeat ($urandom_range(3))
                    send_resend_variant(orig);
            end
            // hold off until every verdict is back
            if ($urandom_range(99) < 3)
                drain_results();
        end
    endtask

    initial
    begin
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_long_packets();
        test_random_traffic(0, 0);
        test_random_traffic(50, 0);
        test_random_traffic(0, 50);
        test_random_traffic(34, 34);
        drain_results();
        repeat (8)
            @(posedge clk);
        if (dup_verdicts.size() != 0)
            report_mismatch($sformatf("%0d verdicts never arrived", dup_verdicts.size()));
        $display("covered %0d requests and %0d packet verdicts, %0d of them duplicates,",
                 requests_sent, verdicts_checked, duplicates_seen);
        $display("with saturated lengths, mixed flags and four idle/stall mixes");
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d verdicts outstanding", dup_verdicts.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
